@@ rtl/flm_pkg.sv @@
// Package with constants, item types and interpolation helpers of the field map lookup.
package flm_pkg;

  localparam int POINTS_X   = 32;
  localparam int POINTS_Y   = 32;
  localparam int POINTS_Z   = 32;
  localparam int FIELD_BITS = 24;

  localparam int POINTS_XY  = (POINTS_X > POINTS_Y) ? POINTS_X : POINTS_Y;
  localparam int POINTS_MAX = (POINTS_XY > POINTS_Z) ? POINTS_XY : POINTS_Z;
  localparam int CELL_W     = $clog2(POINTS_MAX);

  localparam int HALF_X     = (POINTS_X + 1) / 2;
  localparam int HALF_Y     = (POINTS_Y + 1) / 2;
  localparam int HALF_Z     = (POINTS_Z + 1) / 2;
  localparam int BANK_DEPTH = HALF_X * HALF_Y * HALF_Z;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS  = 8;
  localparam int WORD_W     = 3 * FIELD_BITS;
  localparam int PROD_W     = FIELD_BITS + 18;

  localparam logic [31:0] INV_STEP_RESET = 32'd16777216;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic [15:0]                  frac_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic               op;
    logic [4:0]         grid_x;
    logic [4:0]         grid_y;
    logic [4:0]         grid_z;
    logic signed [23:0] load_bx;
    logic signed [23:0] load_by;
    logic signed [23:0] load_bz;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic signed [23:0] field_bx;
    logic signed [23:0] field_by;
    logic signed [23:0] field_bz;
  } out_item_t;

  // First half of lerp(a, b, f) = a + floor(((b - a) * f + 2^15) / 2^16).
  function automatic prod_t lerp_prod(field_t a, field_t b, frac_t f);
    logic signed [FIELD_BITS:0] dlt;
    logic signed [16:0]         fs;
    dlt = (FIELD_BITS+1)'(b) - (FIELD_BITS+1)'(a);
    fs  = $signed({1'b0, f});
    return PROD_W'(dlt) * PROD_W'(fs);
  endfunction

  function automatic field_t lerp_sum(field_t a, prod_t p);
    prod_t t;
    t = (p + PROD_W'(32768)) >>> 16;
    return FIELD_BITS'(t + PROD_W'(a));
  endfunction

endpackage

@@ rtl/flm_in_if.sv @@
// Input item channel of the field map lookup.
interface flm_in_if;
  logic               valid;
  logic               ready;
  flm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/flm_out_if.sv @@
// Result item channel of the field map lookup.
interface flm_out_if;
  logic               valid;
  logic               ready;
  flm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/flm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module flm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/field_map_trilinear_lookup_core.sv @@
// Top level of the trilinear field map lookup with eight parity-interleaved grid banks.
//
// Items enter on in_i. A load item writes one grid point and gives no result.
// A query item gives one result on out_o: the inside flag and the three
// interpolated field components, all zero when the point is off the grid.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// the user must write them only while no item is in flight; the block does not
// enforce it. The grid is split into eight banks by the parity of the x, y and z
// index, so the eight corners of a cell are read from eight banks in the same cycle.
// One item is taken per cycle unless a result waits on out_o and the pipeline
// is full. A query passes ten stages: offset, multiply, sum and cell check,
// bank read, and two stages for each of the three interpolation passes.
// Each stage moves on whenever the stage after it is empty or moving, so
// while a result waits on out_o the block keeps taking items until the
// pipeline is full; it then holds everything until the result is taken.
// Reset clears all valid flags and restores the configuration registers;
// the grid contents are undefined until loaded and need no clearing pass.
module field_map_trilinear_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  flm_in_if.sink      in_i,
  flm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int FW = flm_pkg::FIELD_BITS;
  localparam int CW = flm_pkg::CELL_W;
  localparam int AW = flm_pkg::BANK_AW;

  logic signed [31:0] origin_q [3];
  logic [31:0]        inv_q [3];

  logic [10:1] v_q;
  logic [10:1] en;

  // Stage 1: offsets.
  logic                 op1_q;
  logic [4:0]           g1_q [3];
  flm_pkg::field_t      ld1_q [3];
  logic signed [32:0]   d1_q [3];
  // Stage 2: partial products.
  logic                 op2_q;
  logic [4:0]           g2_q [3];
  flm_pkg::field_t      ld2_q [3];
  logic                 neg2_q [3];
  logic [48:0]          p1_q [3];
  logic [47:0]          p2_q [3];
  // Stage 3: cells and fractions.
  logic                 op3_q;
  logic [4:0]           g3_q [3];
  flm_pkg::field_t      ld3_q [3];
  logic                 in3_q;
  logic [CW-1:0]        c3_q [3];
  flm_pkg::frac_t       f3_q [3];
  // Stage 4: bank data.
  logic                 in4_q;
  flm_pkg::frac_t       f4_q [3];
  logic [2:0]           par4_q;
  logic [flm_pkg::WORD_W-1:0] rdata [flm_pkg::NUM_BANKS];
  // Stages 5 to 10: interpolation and result.
  logic                 in5_q, in6_q, in7_q, in8_q, in9_q;
  flm_pkg::frac_t       fy5_q, fz5_q, fy6_q, fz6_q, fz7_q, fz8_q;
  flm_pkg::field_t      a5_q [3][4];
  flm_pkg::prod_t       p5_q [3][4];
  flm_pkg::field_t      b6_q [3][4];
  flm_pkg::field_t      a7_q [3][2];
  flm_pkg::prod_t       p7_q [3][2];
  flm_pkg::field_t      c8_q [3][2];
  flm_pkg::field_t      a9_q [3];
  flm_pkg::prod_t       p9_q [3];
  flm_pkg::out_item_t   out_q;

  logic                 wr_en;
  logic [2:0]           wr_bank;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr [flm_pkg::NUM_BANKS];
  flm_pkg::field_t      corner [3][8];
  logic signed [31:0]   pt [3];

  function automatic logic [AW-1:0] bank_addr(int xh, int yh, int zh);
    return AW'((xh * flm_pkg::HALF_Y + yh) * flm_pkg::HALF_Z + zh);
  endfunction

  always_comb begin
    en[10] = !v_q[10] || out_o.ready;
    for (int k = 9; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready  = en[1];
  assign out_o.valid = v_q[10];
  assign out_o.data  = out_q;

  assign pt[0] = in_i.data.point_x;
  assign pt[1] = in_i.data.point_y;
  assign pt[2] = in_i.data.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        inv_q[a]    <= flm_pkg::INV_STEP_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        flm_pkg::CFG_ORIGIN_X:   origin_q[0] <= cfg_wdata_i;
        flm_pkg::CFG_ORIGIN_Y:   origin_q[1] <= cfg_wdata_i;
        flm_pkg::CFG_ORIGIN_Z:   origin_q[2] <= cfg_wdata_i;
        flm_pkg::CFG_INV_STEP_X: inv_q[0] <= cfg_wdata_i;
        flm_pkg::CFG_INV_STEP_Y: inv_q[1] <= cfg_wdata_i;
        flm_pkg::CFG_INV_STEP_Z: inv_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1])  v_q[1]  <= in_i.valid;
      if (en[2])  v_q[2]  <= v_q[1];
      if (en[3])  v_q[3]  <= v_q[2];
      if (en[4])  v_q[4]  <= v_q[3] && (op3_q == flm_pkg::OP_QUERY);
      if (en[5])  v_q[5]  <= v_q[4];
      if (en[6])  v_q[6]  <= v_q[5];
      if (en[7])  v_q[7]  <= v_q[6];
      if (en[8])  v_q[8]  <= v_q[7];
      if (en[9])  v_q[9]  <= v_q[8];
      if (en[10]) v_q[10] <= v_q[9];
    end
  end

  // Offset, multiply and cell stages.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op1_q    <= in_i.data.op;
      g1_q[0]  <= in_i.data.grid_x;
      g1_q[1]  <= in_i.data.grid_y;
      g1_q[2]  <= in_i.data.grid_z;
      ld1_q[0] <= FW'(in_i.data.load_bx);
      ld1_q[1] <= FW'(in_i.data.load_by);
      ld1_q[2] <= FW'(in_i.data.load_bz);
      for (int a = 0; a < 3; a++) begin
        d1_q[a] <= 33'(pt[a]) - 33'(origin_q[a]);
      end
    end
    if (en[2]) begin
      op2_q  <= op1_q;
      g2_q   <= g1_q;
      ld2_q  <= ld1_q;
      for (int a = 0; a < 3; a++) begin
        neg2_q[a] <= d1_q[a][32];
        p1_q[a]   <= 49'(d1_q[a][32:16]) * 49'(inv_q[a]);
        p2_q[a]   <= 48'(d1_q[a][15:0]) * 48'(inv_q[a]);
      end
    end
    if (en[3]) begin
      logic [49:0] sum;
      logic        ok;
      op3_q <= op2_q;
      g3_q  <= g2_q;
      ld3_q <= ld2_q;
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
        sum = 50'(p1_q[a]) + 50'(p2_q[a][47:16]);
        c3_q[a] <= CW'(sum[49:24]);
        f3_q[a] <= sum[23:8];
        if (neg2_q[a]) begin
          ok = 1'b0;
        end
        if (a == 0 && sum[49:24] >= 26'(flm_pkg::POINTS_X - 1)) ok = 1'b0;
        if (a == 1 && sum[49:24] >= 26'(flm_pkg::POINTS_Y - 1)) ok = 1'b0;
        if (a == 2 && sum[49:24] >= 26'(flm_pkg::POINTS_Z - 1)) ok = 1'b0;
      end
      in3_q <= ok;
    end
  end

  // Loads write at the same stage where queries read, which keeps item order.
  always_comb begin
    wr_en = en[4] && v_q[3] && (op3_q == flm_pkg::OP_LOAD) &&
            (int'(g3_q[0]) < flm_pkg::POINTS_X) &&
            (int'(g3_q[1]) < flm_pkg::POINTS_Y) &&
            (int'(g3_q[2]) < flm_pkg::POINTS_Z);
    wr_bank = {g3_q[0][0], g3_q[1][0], g3_q[2][0]};
    wr_addr = bank_addr(int'(g3_q[0] >> 1), int'(g3_q[1] >> 1), int'(g3_q[2] >> 1));
    for (int b = 0; b < flm_pkg::NUM_BANKS; b++) begin
      logic [CW:0] xb, yb, zb;
      xb = (CW+1)'(c3_q[0]) + (CW+1)'(b[2] ^ c3_q[0][0]);
      yb = (CW+1)'(c3_q[1]) + (CW+1)'(b[1] ^ c3_q[1][0]);
      zb = (CW+1)'(c3_q[2]) + (CW+1)'(b[0] ^ c3_q[2][0]);
      rd_addr[b] = bank_addr(int'(xb >> 1), int'(yb >> 1), int'(zb >> 1));
    end
  end

  for (genvar b = 0; b < flm_pkg::NUM_BANKS; b++) begin : g_bank
    flm_ram #(
      .WIDTH(flm_pkg::WORD_W),
      .DEPTH(flm_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wr_bank == 3'(b))),
      .waddr_i (wr_addr),
      .wdata_i ({ld3_q[2], ld3_q[1], ld3_q[0]}),
      .re_i    (en[4]),
      .raddr_i (rd_addr[b]),
      .rdata_o (rdata[b])
    );
  end

  // Corner n = {i, j, k} sits in the bank whose parities are n xor the cell parities.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int n = 0; n < 8; n++) begin
        corner[c][n] = rdata[3'(n) ^ par4_q][c*FW +: FW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      in4_q  <= in3_q;
      f4_q   <= f3_q;
      par4_q <= {c3_q[0][0], c3_q[1][0], c3_q[2][0]};
    end
    if (en[5]) begin
      in5_q <= in4_q;
      fy5_q <= f4_q[1];
      fz5_q <= f4_q[2];
      for (int c = 0; c < 3; c++) begin
        for (int jk = 0; jk < 4; jk++) begin
          a5_q[c][jk] <= corner[c][jk];
          p5_q[c][jk] <= flm_pkg::lerp_prod(corner[c][jk], corner[c][jk+4], f4_q[0]);
        end
      end
    end
    if (en[6]) begin
      in6_q <= in5_q;
      fy6_q <= fy5_q;
      fz6_q <= fz5_q;
      for (int c = 0; c < 3; c++) begin
        for (int jk = 0; jk < 4; jk++) begin
          b6_q[c][jk] <= flm_pkg::lerp_sum(a5_q[c][jk], p5_q[c][jk]);
        end
      end
    end
    if (en[7]) begin
      in7_q <= in6_q;
      fz7_q <= fz6_q;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 2; k++) begin
          a7_q[c][k] <= b6_q[c][k];
          p7_q[c][k] <= flm_pkg::lerp_prod(b6_q[c][k], b6_q[c][k+2], fy6_q);
        end
      end
    end
    if (en[8]) begin
      in8_q <= in7_q;
      fz8_q <= fz7_q;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 2; k++) begin
          c8_q[c][k] <= flm_pkg::lerp_sum(a7_q[c][k], p7_q[c][k]);
        end
      end
    end
    if (en[9]) begin
      in9_q <= in8_q;
      for (int c = 0; c < 3; c++) begin
        a9_q[c] <= c8_q[c][0];
        p9_q[c] <= flm_pkg::lerp_prod(c8_q[c][0], c8_q[c][1], fz8_q);
      end
    end
    if (en[10]) begin
      out_q.inside_res <= in9_q;
      out_q.field_bx   <= in9_q ? 24'(flm_pkg::lerp_sum(a9_q[0], p9_q[0])) : '0;
      out_q.field_by   <= in9_q ? 24'(flm_pkg::lerp_sum(a9_q[1], p9_q[1])) : '0;
      out_q.field_bz   <= in9_q ? 24'(flm_pkg::lerp_sum(a9_q[2], p9_q[2])) : '0;
    end
  end

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[4] && v_q[3] && op3_q == flm_pkg::OP_LOAD) |=> !v_q[4])
    else $error("A load item entered the read stage.");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[10] && !out_q.inside_res) |->
      (out_q.field_bx == '0 && out_q.field_by == '0 && out_q.field_bz == '0))
    else $error("An outside result carries nonzero field.");

  a_no_write_on_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (v_q[3] && op3_q == flm_pkg::OP_LOAD))
    else $error("A grid bank write came from a query item.");

endmodule

@@ tb/tb_field_map_trilinear_lookup_core.sv @@
// Self-checking testbench of the trilinear field map lookup: directed and random items.
`timescale 1ns / 1ps

module tb_field_map_trilinear_lookup_core;

  typedef struct {
    flm_pkg::in_item_t  it;
    bit                 typed;
    flm_pkg::out_item_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  flm_in_if  in_ch ();
  flm_out_if out_ch ();

  field_map_trilinear_lookup_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  localparam int GRID_N = flm_pkg::POINTS_X * flm_pkg::POINTS_Y * flm_pkg::POINTS_Z;

  logic signed [31:0] org [3];
  logic [31:0]        inv [3];
  flm_pkg::field_t    grid_mem [3][GRID_N];
  bit                 grid_set [GRID_N];
  flm_pkg::out_item_t field_q [$];
  int                 errors;
  int                 n_sent;
  int                 n_query;
  int                 n_inside;
  int                 n_checked;
  bit                 calm;
  bit                 hold_req;
  dir_row_t           rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int grid_addr(int x, int y, int z);
    return (x * flm_pkg::POINTS_Y + y) * flm_pkg::POINTS_Z + z;
  endfunction

  function automatic bit map_axis(logic signed [31:0] p, logic signed [31:0] o,
                                  logic [31:0] iv, int pts,
                                  output int cidx, output longint fr);
    longint d;
    longint unsigned hi, lo, v;
    cidx = 0;
    fr = 0;
    d = longint'(p) - longint'(o);
    if (d < 0) return 0;
    hi = longint'(d) >> 16;
    lo = longint'(d) & 64'hFFFF;
    v = (hi * iv + ((lo * iv) >> 16)) >> 8;
    fr = v & 64'hFFFF;
    if ((v >> 16) >= pts - 1) return 0;
    cidx = int'(v >> 16);
    return 1;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic bit locate(flm_pkg::in_item_t it, output int c[3], output longint f[3]);
    bit ok;
    ok = map_axis(it.point_x, org[0], inv[0], flm_pkg::POINTS_X, c[0], f[0]);
    ok = ok && map_axis(it.point_y, org[1], inv[1], flm_pkg::POINTS_Y, c[1], f[1]);
    ok = ok && map_axis(it.point_z, org[2], inv[2], flm_pkg::POINTS_Z, c[2], f[2]);
    return ok;
  endfunction

  function automatic flm_pkg::out_item_t interpolate(flm_pkg::in_item_t it);
    flm_pkg::out_item_t r;
    int        c[3];
    longint    f[3];
    longint    k[2][2][2];
    longint    v[3];
    r = '0;
    if (!locate(it, c, f)) return r;
    for (int n = 0; n < 3; n++) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          for (int m = 0; m < 2; m++)
            k[i][j][m] = grid_mem[n][grid_addr(c[0] + i, c[1] + j, c[2] + m)];
      v[n] = blend(blend(blend(k[0][0][0], k[1][0][0], f[0]),
                         blend(k[0][1][0], k[1][1][0], f[0]), f[1]),
                   blend(blend(k[0][0][1], k[1][0][1], f[0]),
                         blend(k[0][1][1], k[1][1][1], f[0]), f[1]), f[2]);
    end
    r.inside_res = 1'b1;
    r.field_bx = v[0][23:0];
    r.field_by = v[1][23:0];
    r.field_bz = v[2][23:0];
    return r;
  endfunction

  function automatic flm_pkg::in_item_t mk_load(int x, int y, int z, int bx, int by, int bz);
    flm_pkg::in_item_t it;
    it = '0;
    it.op = flm_pkg::OP_LOAD;
    it.grid_x = 5'(x);
    it.grid_y = 5'(y);
    it.grid_z = 5'(z);
    it.load_bx = 24'(bx);
    it.load_by = 24'(by);
    it.load_bz = 24'(bz);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    return it;
  endfunction

  function automatic flm_pkg::in_item_t mk_query(int px, int py, int pz);
    flm_pkg::in_item_t it;
    it = '0;
    it.op = flm_pkg::OP_QUERY;
    it.grid_x = 5'($urandom);
    it.grid_y = 5'($urandom);
    it.grid_z = 5'($urandom);
    it.load_bx = 24'($urandom);
    it.load_by = 24'($urandom);
    it.load_bz = 24'($urandom);
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    return it;
  endfunction

  function automatic logic [31:0] pick_coord(int a, int pts);
    longint v, d;
    int     r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return org[a] - $urandom_range(1, 70000);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = longint'(pts - 1) << 16;
      default: v = $urandom_range(0, ((pts - 1) << 16) - 1);
    endcase
    if (inv[a] == 0) d = $urandom_range(0, 1 << 20);
    else d = (v << 24) / inv[a];
    return org[a] + d[31:0];
  endfunction

  task automatic push_item(flm_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_sent++;
    if (it.op == flm_pkg::OP_LOAD) begin
      grid_mem[0][grid_addr(it.grid_x, it.grid_y, it.grid_z)] = it.load_bx;
      grid_mem[1][grid_addr(it.grid_x, it.grid_y, it.grid_z)] = it.load_by;
      grid_mem[2][grid_addr(it.grid_x, it.grid_y, it.grid_z)] = it.load_bz;
      grid_set[grid_addr(it.grid_x, it.grid_y, it.grid_z)] = 1'b1;
    end
  endtask

  task automatic send_and_predict(flm_pkg::in_item_t it);
    push_item(it);
    if (it.op == flm_pkg::OP_QUERY) begin
      field_q.push_back(interpolate(it));
      n_query++;
    end
  endtask

  // Loads any missing corner of the target cell before a query.
  task automatic send_query(flm_pkg::in_item_t it);
    int     c[3];
    longint f[3];
    int     a;
    if (locate(it, c, f)) begin
      n_inside++;
      for (int i = 0; i < 8; i++) begin
        a = grid_addr(c[0] + i[2], c[1] + i[1], c[2] + i[0]);
        if (!grid_set[a])
          send_and_predict(mk_load(c[0] + i[2], c[1] + i[1], c[2] + i[0],
                                   $urandom, $urandom, $urandom));
      end
    end
    send_and_predict(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (field_q.size() == 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(flm_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx <= flm_pkg::CFG_ORIGIN_Z) org[idx] = val;
    else inv[idx - flm_pkg::CFG_INV_STEP_X] = val;
  endtask

  task automatic set_config(logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                            logic [31:0] s0, logic [31:0] s1, logic [31:0] s2);
    drain();
    write_reg(flm_pkg::CFG_ORIGIN_X, o0);
    write_reg(flm_pkg::CFG_ORIGIN_Y, o1);
    write_reg(flm_pkg::CFG_ORIGIN_Z, o2);
    write_reg(flm_pkg::CFG_INV_STEP_X, s0);
    write_reg(flm_pkg::CFG_INV_STEP_Y, s1);
    write_reg(flm_pkg::CFG_INV_STEP_Z, s2);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int stop;
    stop = n_sent + count;
    while (n_sent < stop) begin
      if ($urandom_range(0, 4) == 0)
        send_and_predict(mk_load($urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 31), $urandom, $urandom, $urandom));
      else
        send_query(mk_query(pick_coord(0, flm_pkg::POINTS_X),
                            pick_coord(1, flm_pkg::POINTS_Y),
                            pick_coord(2, flm_pkg::POINTS_Z)));
    end
  endtask

  always @(posedge clk_i) begin
    flm_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (field_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_ch.data);
        errors++;
      end else begin
        want = field_q.pop_front();
        n_checked++;
        if (out_ch.data.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %0b actual %0b", $time,
                   want.inside_res, out_ch.data.inside_res);
          errors++;
        end
        if (out_ch.data.field_bx !== want.field_bx) begin
          $display("%0t: field_bx expected %0d actual %0d", $time,
                   want.field_bx, out_ch.data.field_bx);
          errors++;
        end
        if (out_ch.data.field_by !== want.field_by) begin
          $display("%0t: field_by expected %0d actual %0d", $time,
                   want.field_by, out_ch.data.field_by);
          errors++;
        end
        if (out_ch.data.field_bz !== want.field_bz) begin
          $display("%0t: field_bz expected %0d actual %0d", $time,
                   want.field_bz, out_ch.data.field_bz);
          errors++;
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = flm_pkg::CFG_ORIGIN_X;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    errors = 0;
    n_sent = 0;
    n_query = 0;
    n_inside = 0;
    n_checked = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    org = '{0, 0, 0};
    inv = '{flm_pkg::INV_STEP_RESET, flm_pkg::INV_STEP_RESET, flm_pkg::INV_STEP_RESET};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 8; i++) begin
      r.typed = 1'b0;
      r.res = '0;
      r.it = (i == 0) ? mk_load(0, 0, 0, 8388607, 8388607, 8388607)
                      : mk_load(i[2], i[1], i[0], -8388608, 1234567, -1);
      rows.push_back(r);
      r.it = (i == 0) ? mk_load(30, 30, 30, -8388608, -8388608, -8388608)
                      : mk_load(30 + i[2], 30 + i[1], 30 + i[0], 8388607, -7654321, 0);
      rows.push_back(r);
    end
    r.typed = 1'b1;
    r.it = mk_query(0, 0, 0);
    r.res = '{1'b1, 24'sd8388607, 24'sd8388607, 24'sd8388607};
    rows.push_back(r);
    r.it = mk_query(30 << 16, 30 << 16, 30 << 16);
    r.res = '{1'b1, -24'sd8388608, -24'sd8388608, -24'sd8388608};
    rows.push_back(r);
    r.res = '0;
    r.it = mk_query(-1, 0, 0);
    rows.push_back(r);
    r.it = mk_query(0, 31 << 16, 0);
    rows.push_back(r);
    r.it = mk_query(32'h7FFFFFFF, 32'h80000000, 0);
    rows.push_back(r);
    r.typed = 1'b0;
    r.it = mk_query(32'h8000, 32'hFFFF, 32'h1);
    rows.push_back(r);
    r.it = mk_query((30 << 16) + 32'hFFFF, (30 << 16) + 32'h8000, 30 << 16);
    rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        push_item(rows[i].it);
        field_q.push_back(rows[i].res);
        n_query++;
      end else begin
        send_and_predict(rows[i].it);
      end
    end

    random_phase(250);
    hold_req = 1'b1;
    random_phase(60);
    drain();
    random_phase(40);
    set_config($urandom, $urandom, $urandom, $urandom_range(1 << 22, 1 << 26),
               $urandom_range(1 << 22, 1 << 26), $urandom_range(1 << 22, 1 << 26));
    random_phase(200);
    set_config(32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 0, 32'hFFFFFFFF, 0);
    random_phase(150);
    set_config(32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
    random_phase(150);
    set_config(-(5 << 16), 3 << 16, 32'h00012345, 32'h00800000, 32'h02000000, 32'h01000001);
    random_phase(200);
    set_config(0, 0, 0, flm_pkg::INV_STEP_RESET, flm_pkg::INV_STEP_RESET,
               flm_pkg::INV_STEP_RESET);
    calm = 1'b1;
    random_phase(230);
    drain();

    $display("Covered %0d items, %0d queries (%0d inside the grid), %0d results checked.",
             n_sent, n_query, n_inside, n_checked);
    $display("Six register settings were used, including zero and full-scale steps.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/flm_pkg.sv
rtl/flm_in_if.sv
rtl/flm_out_if.sv
rtl/flm_ram.sv
rtl/field_map_trilinear_lookup_core.sv
tb/tb_field_map_trilinear_lookup_core.sv
